FILE: design/mtw_pkg.sv
// Package for the multi-task heartbeat watchdog: constants, codes and shared types.
package mtw_pkg;

  localparam int NUM_TASKS = 8;
  localparam int TASK_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W     = $clog2(NUM_TASKS + 1);

  localparam int OP_W     = 3;
  localparam int ID_W     = 3;
  localparam int TICK_W   = 32;
  localparam int STRIKE_W = 9;
  localparam int WIN_W    = 17;

  // Opcodes carried with each input transaction.
  localparam logic [OP_W-1:0] OP_DISABLE   = 3'd0;
  localparam logic [OP_W-1:0] OP_ENABLE    = 3'd1;
  localparam logic [OP_W-1:0] OP_HEARTBEAT = 3'd2;
  localparam logic [OP_W-1:0] OP_LOAD      = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK     = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_WDG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_WINDOW_LIMIT = 2'd1;
  localparam logic [1:0] REG_WINDOW_STEP  = 2'd2;
  localparam logic [1:0] REG_STRIKE_LIMIT = 2'd3;

  localparam logic        RST_WDG_ENABLE   = 1'b1;
  localparam logic [15:0] RST_WINDOW_LIMIT = 16'd10000;
  localparam logic [7:0]  RST_WINDOW_STEP  = 8'd2;
  localparam logic [7:0]  RST_STRIKE_LIMIT = 8'd5;

  localparam logic [STRIKE_W-1:0] STRIKE_MAX = '1;

  // Write command into the task store.
  typedef struct packed {
    logic              we;
    logic [OP_W-1:0]   op;
    logic [TASK_W-1:0] idx;
    logic [TICK_W-1:0] data;
  } store_wr_t;

  // Registered read data of one task entry.
  typedef struct packed {
    logic              enabled;
    logic [TICK_W-1:0] stamp;
    logic [TICK_W-1:0] interval;
  } store_rd_t;

endpackage

FILE: design/mtw_task_store.sv
// Task store: heartbeat stamp and interval memories with valid bits, and task enable bits.
module mtw_task_store
  import mtw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  store_wr_t         wr,
  input  logic [TASK_W-1:0] rd_addr,
  output store_rd_t         rd
);

  logic [TICK_W-1:0]    stamp_mem [NUM_TASKS];
  logic [TICK_W-1:0]    ival_mem  [NUM_TASKS];
  logic [NUM_TASKS-1:0] stamp_vld;
  logic [NUM_TASKS-1:0] ival_vld;
  logic [NUM_TASKS-1:0] task_en;

  logic [TICK_W-1:0] stamp_raw;
  logic [TICK_W-1:0] ival_raw;
  logic              stamp_raw_vld;
  logic              ival_raw_vld;
  logic              en_raw;

  // Entries that were never written read as zero through their valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_vld <= '0;
      ival_vld  <= '0;
      task_en   <= '0;
    end else if (wr.we) begin
      case (wr.op)
        OP_DISABLE:   task_en[wr.idx]   <= 1'b0;
        OP_ENABLE:    task_en[wr.idx]   <= 1'b1;
        OP_HEARTBEAT: stamp_vld[wr.idx] <= 1'b1;
        OP_LOAD:      ival_vld[wr.idx]  <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we && wr.op == OP_HEARTBEAT) begin
      stamp_mem[wr.idx] <= wr.data;
    end
    if (wr.we && wr.op == OP_LOAD) begin
      ival_mem[wr.idx] <= wr.data;
    end
    stamp_raw     <= stamp_mem[rd_addr];
    ival_raw      <= ival_mem[rd_addr];
    stamp_raw_vld <= stamp_vld[rd_addr];
    ival_raw_vld  <= ival_vld[rd_addr];
    en_raw        <= task_en[rd_addr];
  end

  assign rd.enabled  = en_raw;
  assign rd.stamp    = stamp_raw_vld ? stamp_raw : '0;
  assign rd.interval = ival_raw_vld ? ival_raw : '0;

endmodule

FILE: design/multi_task_heartbeat_watchdog.sv
// Top level of the multi-task heartbeat watchdog supervisor.
//
//   Channel  Direction  Signals                          Content
//   s_*      in         s_tvalid s_tready s_tdata s_tuser  command transaction
//   m_*      out        m_tvalid m_tready m_tdata          one result per command
//   cfg_*    in         cfg_we cfg_index cfg_data          register writes
//
// A command other than an active check produces its result at the edge that accepts it.
// An active check scans the task store one entry per cycle and finishes on the first
// overdue task or after the last entry; entries are read one at a time through the
// single read port of the task store.
// Reset (rst, synchronous) clears the enable bits, the valid bits of both memories and
// all counters, and loads the register defaults. A stalled result is held in the output
// register; when no scan runs, a new command is taken once it is free or being emptied.
module multi_task_heartbeat_watchdog
  import mtw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // task_id[2:0], now_tick[34:3], interval_value[66:35]
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // kick[0], halted[1], overdue_seen[2], overdue_task[5:3]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // Configuration registers.
  logic        wdg_enable;
  logic [15:0] window_limit;
  logic [7:0]  window_step;
  logic [7:0]  strike_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      wdg_enable   <= RST_WDG_ENABLE;
      window_limit <= RST_WINDOW_LIMIT;
      window_step  <= RST_WINDOW_STEP;
      strike_limit <= RST_STRIKE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WDG_ENABLE:   wdg_enable   <= cfg_data[0];
        REG_WINDOW_LIMIT: window_limit <= cfg_data;
        REG_WINDOW_STEP:  window_step  <= cfg_data[7:0];
        REG_STRIKE_LIMIT: strike_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Unpack the incoming transaction.
  logic [OP_W-1:0]   in_op;
  logic [ID_W-1:0]   in_id;
  logic [TICK_W-1:0] in_now;
  logic [TICK_W-1:0] in_ival;

  assign in_op   = s_tuser;
  assign in_id   = s_tdata[2:0];
  assign in_now  = s_tdata[34:3];
  assign in_ival = s_tdata[66:35];

  // Control and shared state.
  logic                state;
  logic [CNT_W-1:0]    issue_cnt;
  logic                eval_vld;
  logic [TASK_W-1:0]   eval_idx;
  logic [TICK_W-1:0]   now_hold;
  logic [WIN_W-1:0]    window_count;
  logic [STRIKE_W-1:0] strike_count;
  logic                halt_flag;

  logic accept;
  logic id_ok;
  logic check_active;

  assign s_tready     = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept       = s_tvalid && s_tready;
  assign id_ok        = int'(in_id) < NUM_TASKS;
  assign check_active = (in_op == OP_CHECK) && wdg_enable && !halt_flag;

  // Store writes happen only while idle, and read data is used only while scanning, so
  // a write never touches an entry whose read data is in use in the same cycle.
  store_wr_t         st_wr;
  store_rd_t         st_rd;
  logic [TASK_W-1:0] rd_addr;

  assign st_wr.we   = accept && id_ok && (in_op != OP_CHECK) && (in_op <= OP_LOAD);
  assign st_wr.op   = in_op;
  assign st_wr.idx  = TASK_W'(in_id);
  assign st_wr.data = (in_op == OP_LOAD) ? in_ival : in_now;
  assign rd_addr    = issue_cnt[TASK_W-1:0];

  mtw_task_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (st_wr),
    .rd_addr (rd_addr),
    .rd      (st_rd)
  );

  // Window update taken at the accepting edge of an active check.
  logic [WIN_W-1:0] window_sum;
  logic             window_wrap;

  assign window_sum  = window_count + WIN_W'(window_step);
  assign window_wrap = window_sum > WIN_W'(window_limit);

  // Elapsed ticks with the rollover rule that is one tick short on wrap.
  logic [TICK_W:0]   diff;
  logic [TICK_W-1:0] elapsed;
  logic              hit;

  assign diff    = {1'b0, now_hold} - {1'b0, st_rd.stamp};
  assign elapsed = diff[TICK_W-1:0] - TICK_W'(diff[TICK_W]);
  assign hit     = eval_vld && st_rd.enabled && (st_rd.interval != '0) &&
                   (st_rd.stamp != '0) && (elapsed >= st_rd.interval);

  logic [STRIKE_W-1:0] strike_inc;
  logic                halt_new;
  logic                scan_done;

  assign strike_inc = (strike_count < STRIKE_MAX) ? strike_count + 1'b1 : strike_count;
  assign halt_new   = halt_flag || (strike_inc > STRIKE_W'(strike_limit));
  assign scan_done  = eval_vld && (hit || int'(eval_idx) == NUM_TASKS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      issue_cnt    <= '0;
      eval_vld     <= 1'b0;
      window_count <= '0;
      strike_count <= '0;
      halt_flag    <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (check_active) begin
              state     <= ST_SCAN;
              issue_cnt <= '0;
              eval_vld  <= 1'b0;
              if (window_wrap) begin
                window_count <= '0;
                strike_count <= '0;
              end else begin
                window_count <= window_sum;
              end
            end else begin
              m_tvalid <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (int'(issue_cnt) < NUM_TASKS) begin
            issue_cnt <= issue_cnt + 1'b1;
            eval_vld  <= 1'b1;
          end else begin
            eval_vld <= 1'b0;
          end
          if (scan_done) begin
            state    <= ST_IDLE;
            eval_vld <= 1'b0;
            m_tvalid <= 1'b1;
            if (hit) begin
              strike_count <= strike_inc;
              halt_flag    <= halt_new;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers: index of the entry in flight, held tick, and the result.
  always_ff @(posedge clk) begin
    eval_idx <= rd_addr;
    if (accept) begin
      now_hold <= in_now;
      if (!check_active) begin
        m_tdata <= {2'b00, 3'd0, 1'b0, halt_flag, 1'b0};
      end
    end
    if (state == ST_SCAN && scan_done) begin
      if (hit) begin
        m_tdata <= {2'b00, 3'(eval_idx), 1'b1, halt_new, !halt_new};
      end else begin
        m_tdata <= {2'b00, 3'd0, 1'b0, halt_flag, 1'b1};
      end
    end
  end

endmodule
